// ===== hw/rtl/dtau_pkg.sv =====
// Shared constants, command codes and types of the distance and triangle area unit.
package dtau_pkg;

   // Default geometry of the data path
   localparam int DEF_COORD_WIDTH   = 16;
   localparam int DEF_FRACTION_BITS = 8;

   // Fixed widths of the result fields
   localparam int CMD_WIDTH      = 2;
   localparam int DIST_WIDTH     = 16;
   localparam int RESULT_WIDTH   = 32;
   localparam int RSP_DATA_WIDTH = 2 * DIST_WIDTH + RESULT_WIDTH;

   typedef logic [CMD_WIDTH-1:0] command_type;

   // Command codes; the fourth code is reserved and yields an all-zero result
   localparam command_type CMD_DISTANCE    = 2'd0;
   localparam command_type CMD_AREA_POINTS = 2'd1;
   localparam command_type CMD_AREA_SIDES  = 2'd2;

endpackage

// ===== hw/rtl/dtau_isqrt.sv =====
// Pipelined floor square root, one root bit resolved per register stage.
module dtau_isqrt #(
   parameter int RAD_WIDTH = 2 * dtau_pkg::DEF_COORD_WIDTH + 2,
   parameter int TAG_WIDTH = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [RAD_WIDTH-1:0]   in_radicand,
   input  logic [TAG_WIDTH-1:0]   in_tag,
   output logic                   out_valid,
   output logic [RAD_WIDTH/2-1:0] out_root,
   output logic [TAG_WIDTH-1:0]   out_tag
);
   import dtau_pkg::*;

   localparam int ROOT_WIDTH = RAD_WIDTH / 2;
   localparam int REM_WIDTH  = ROOT_WIDTH + 3;

   logic                  valid_ff [ROOT_WIDTH];
   logic [RAD_WIDTH-1:0]  rad_ff   [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  rem_ff   [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff  [ROOT_WIDTH];
   logic [TAG_WIDTH-1:0]  tag_ff   [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
      logic                  valid_prev;
      logic [RAD_WIDTH-1:0]  rad_prev;
      logic [REM_WIDTH-1:0]  rem_prev;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic [TAG_WIDTH-1:0]  tag_prev;
      logic [REM_WIDTH-1:0]  cur;
      logic [REM_WIDTH-1:0]  trial;
      logic                  fits;
      logic [RAD_WIDTH-1:0]  rad_in;
      logic [REM_WIDTH-1:0]  rem_in;
      logic [ROOT_WIDTH-1:0] root_in;

      // Take the previous stage, or the input beat at the head
      if (k == 0) begin : g_head
         assign valid_prev = in_valid;
         assign rad_prev   = in_radicand;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign tag_prev   = in_tag;
      end else begin : g_body
         assign valid_prev = valid_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      // Bring down the next bit pair and try the next root bit
      assign cur     = {rem_prev[REM_WIDTH-3:0], rad_prev[RAD_WIDTH-1 -: 2]};
      assign trial   = REM_WIDTH'({root_prev, 2'b01});
      assign fits    = (cur >= trial);
      assign rad_in  = rad_prev << 2;
      assign rem_in  = fits ? (cur - trial) : cur;
      assign root_in = {root_prev[ROOT_WIDTH-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];
   assign out_tag   = tag_ff[ROOT_WIDTH-1];

endmodule

// ===== hw/rtl/dtau_split_mul.sv =====
// Two-stage wide multiplier built from four half-width partial products.
module dtau_split_mul #(
   parameter int WIDTH     = 2 * dtau_pkg::DEF_COORD_WIDTH + 4,
   parameter int TAG_WIDTH = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [WIDTH-1:0]     in_a,
   input  logic [WIDTH-1:0]     in_b,
   input  logic [TAG_WIDTH-1:0] in_tag,
   output logic                 out_valid,
   output logic [2*WIDTH-1:0]   out_product,
   output logic [TAG_WIDTH-1:0] out_tag
);
   import dtau_pkg::*;

   localparam int HALF = WIDTH / 2;
   localparam int HI_W = WIDTH - HALF;
   localparam int PPW  = 2 * HI_W;

   logic [PPW-1:0]       pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [PPW-1:0]       pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic                 pp_valid_ff;
   logic [TAG_WIDTH-1:0] pp_tag_ff;
   logic [2*WIDTH-1:0]   product_in, product_ff;
   logic                 product_valid_ff;
   logic [TAG_WIDTH-1:0] product_tag_ff;

   // Form the four partial products
   always_comb begin
      pp_ll_in = PPW'(in_a[HALF-1:0])     * PPW'(in_b[HALF-1:0]);
      pp_lh_in = PPW'(in_a[HALF-1:0])     * PPW'(in_b[WIDTH-1:HALF]);
      pp_hl_in = PPW'(in_a[WIDTH-1:HALF]) * PPW'(in_b[HALF-1:0]);
      pp_hh_in = PPW'(in_a[WIDTH-1:HALF]) * PPW'(in_b[WIDTH-1:HALF]);
   end

   // Weight and add the partial products
   always_comb begin
      product_in = (2*WIDTH)'(pp_ll_ff)
                 + ((2*WIDTH)'(pp_lh_ff) << HALF)
                 + ((2*WIDTH)'(pp_hl_ff) << HALF)
                 + ((2*WIDTH)'(pp_hh_ff) << (2 * HALF));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff      <= 1'b0;
         product_valid_ff <= 1'b0;
      end else if (enable) begin
         pp_valid_ff      <= in_valid;
         product_valid_ff <= pp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pp_ll_ff       <= pp_ll_in;
         pp_lh_ff       <= pp_lh_in;
         pp_hl_ff       <= pp_hl_in;
         pp_hh_ff       <= pp_hh_in;
         pp_tag_ff      <= in_tag;
         product_ff     <= product_in;
         product_tag_ff <= pp_tag_ff;
      end
   end

   assign out_valid   = product_valid_ff;
   assign out_product = product_ff;
   assign out_tag     = product_tag_ff;

endmodule

// ===== hw/rtl/distance_and_triangle_area_unit.sv =====
// Top level: fixed-point Euclidean distance and Heron triangle area pipeline.
//
//   channel   direction   tdata                                  tuser
//   req       in          9 coordinate and side fields           command
//   rsp       out         x_distance, y_distance, result_value   invalid
//
// One beat is accepted every cycle while the skid register is empty. The
// pipeline is deepest in its bit-serial square-root pipelines: the side roots
// take COORD_WIDTH + 1 stages, the final root half the width of its radicand.
// Reset clears only the valid bits. A stalled rsp fills a one-beat skid
// register; while it is full the whole pipeline holds and req_tready is low.
module distance_and_triangle_area_unit #(
   parameter int COORD_WIDTH   = dtau_pkg::DEF_COORD_WIDTH,
   parameter int FRACTION_BITS = dtau_pkg::DEF_FRACTION_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y,
   // side_ab, side_bc, side_ca, zero fill
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   // command
   input  logic [dtau_pkg::CMD_WIDTH-1:0]          req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // x_distance, y_distance, result_value
   output logic [dtau_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // invalid
   output logic                                    rsp_tuser
);
   import dtau_pkg::*;

   localparam int W       = COORD_WIDTH;
   localparam int F       = FRACTION_BITS;
   localparam int SUM_W   = 2 * W + 1;
   localparam int SRAD_W  = 2 * W + 2;
   localparam int SIDE_W  = W + 1;
   localparam int PROD_W  = 2 * SIDE_W + 2;
   localparam int XY_W    = 2 * SIDE_W + 3;
   localparam int DRAD_W  = SUM_W + 2 * F;
   localparam int RAD_W0  = (2 * PROD_W > DRAD_W) ? 2 * PROD_W : DRAD_W;
   localparam int RAD_W   = RAD_W0 + (RAD_W0 % 2);
   localparam int ROOT_W  = RAD_W / 2;
   localparam int VAL_W   = (ROOT_W > RESULT_WIDTH) ? ROOT_W : RESULT_WIDTH;
   localparam int TAG_AB  = CMD_WIDTH + 2 * W + SUM_W;
   localparam int TAG_MUL = TAG_AB + 1;
   localparam int TAG_FIN = CMD_WIDTH + 2 * W + 1;

   logic en;

   function automatic logic [W-1:0] abs_diff(input logic [W-1:0] p, input logic [W-1:0] q);
      logic signed [W:0] d;
      logic signed [W:0] n;
      d = $signed({p[W-1], p}) - $signed({q[W-1], q});
      n = -d;
      return d[W] ? n[W-1:0] : d[W-1:0];
   endfunction

   // ---------------------------------------------------------------- stage 1
   logic [W-1:0] ax, ay, bx, by, cx, cy;
   logic         v1_ff;
   command_type  cmd1_ff;
   logic [W-1:0] dabx1_in, daby1_in, dbcx1_in, dbcy1_in, dcax1_in, dcay1_in;
   logic [W-1:0] dabx1_ff, daby1_ff, dbcx1_ff, dbcy1_ff, dcax1_ff, dcay1_ff;
   logic [W-1:0] sab1_ff, sbc1_ff, sca1_ff;

   assign ax = req_tdata[0*W +: W];
   assign ay = req_tdata[1*W +: W];
   assign bx = req_tdata[2*W +: W];
   assign by = req_tdata[3*W +: W];
   assign cx = req_tdata[4*W +: W];
   assign cy = req_tdata[5*W +: W];

   // Take axis distances of the three point pairs
   always_comb begin
      dabx1_in = abs_diff(ax, bx);
      daby1_in = abs_diff(ay, by);
      dbcx1_in = abs_diff(bx, cx);
      dbcy1_in = abs_diff(by, cy);
      dcax1_in = abs_diff(cx, ax);
      dcay1_in = abs_diff(cy, ay);
   end

   // ---------------------------------------------------------------- stage 2
   logic           v2_ff;
   command_type    cmd2_ff;
   logic [2*W-1:0] qabx2_in, qaby2_in, qbcx2_in, qbcy2_in, qcax2_in, qcay2_in;
   logic [2*W-1:0] qabx2_ff, qaby2_ff, qbcx2_ff, qbcy2_ff, qcax2_ff, qcay2_ff;
   logic [W-1:0]   dabx2_ff, daby2_ff, sab2_ff, sbc2_ff, sca2_ff;

   // Square each axis distance
   always_comb begin
      qabx2_in = (2*W)'(dabx1_ff) * (2*W)'(dabx1_ff);
      qaby2_in = (2*W)'(daby1_ff) * (2*W)'(daby1_ff);
      qbcx2_in = (2*W)'(dbcx1_ff) * (2*W)'(dbcx1_ff);
      qbcy2_in = (2*W)'(dbcy1_ff) * (2*W)'(dbcy1_ff);
      qcax2_in = (2*W)'(dcax1_ff) * (2*W)'(dcax1_ff);
      qcay2_in = (2*W)'(dcay1_ff) * (2*W)'(dcay1_ff);
   end

   // ---------------------------------------------------------------- stage 3
   logic             v3_ff;
   command_type      cmd3_ff;
   logic [SUM_W-1:0] ssab3_in, ssbc3_in, ssca3_in;
   logic [SUM_W-1:0] ssab3_ff, ssbc3_ff, ssca3_ff;
   logic [W-1:0]     dabx3_ff, daby3_ff, sab3_ff, sbc3_ff, sca3_ff;

   // Add the squares per point pair
   always_comb begin
      ssab3_in = SUM_W'(qabx2_ff) + SUM_W'(qaby2_ff);
      ssbc3_in = SUM_W'(qbcx2_ff) + SUM_W'(qbcy2_ff);
      ssca3_in = SUM_W'(qcax2_ff) + SUM_W'(qcay2_ff);
   end

   // ------------------------------------------------------------ side roots
   logic              ab_v, bc_v, ca_v;
   logic [SIDE_W-1:0] ab_root, bc_root, ca_root;
   logic [TAG_AB-1:0] ab_tag;
   logic [2*W-1:0]    bc_tag;
   logic [W-1:0]      ca_tag;

   dtau_isqrt #(.RAD_WIDTH(SRAD_W), .TAG_WIDTH(TAG_AB)) u_sqrt_ab (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v3_ff),
      .in_radicand(SRAD_W'(ssab3_ff)),
      .in_tag({cmd3_ff, dabx3_ff, daby3_ff, ssab3_ff}),
      .out_valid(ab_v), .out_root(ab_root), .out_tag(ab_tag)
   );

   dtau_isqrt #(.RAD_WIDTH(SRAD_W), .TAG_WIDTH(2 * W)) u_sqrt_bc (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v3_ff),
      .in_radicand(SRAD_W'(ssbc3_ff)),
      .in_tag({sab3_ff, sbc3_ff}),
      .out_valid(bc_v), .out_root(bc_root), .out_tag(bc_tag)
   );

   dtau_isqrt #(.RAD_WIDTH(SRAD_W), .TAG_WIDTH(W)) u_sqrt_ca (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v3_ff),
      .in_radicand(SRAD_W'(ssca3_ff)),
      .in_tag(sca3_ff),
      .out_valid(ca_v), .out_root(ca_root), .out_tag(ca_tag)
   );

   // ---------------------------------------------------------------- stage 4
   command_type       cmd_r;
   logic [SIDE_W-1:0] side_a, side_b, side_c;
   logic              v4_ff;
   logic [SIDE_W:0]   bsum4_in, bsum4_ff;
   logic [SIDE_W-1:0] bdif4_in, bdif4_ff, a4_ff;
   logic [TAG_AB-1:0] tag4_ff;

   assign cmd_r = ab_tag[TAG_AB-1 -: CMD_WIDTH];

   // Pick the sides and form b + c and |b - c|
   always_comb begin
      if (cmd_r == CMD_AREA_POINTS) begin
         side_a = ab_root;
         side_b = bc_root;
         side_c = ca_root;
      end else begin
         side_a = SIDE_W'(bc_tag[2*W-1:W]);
         side_b = SIDE_W'(bc_tag[W-1:0]);
         side_c = SIDE_W'(ca_tag);
      end
      bsum4_in = (SIDE_W+1)'(side_b) + (SIDE_W+1)'(side_c);
      bdif4_in = (side_b >= side_c) ? (side_b - side_c) : (side_c - side_b);
   end

   // ---------------------------------------------------------------- stage 5
   logic                v5_ff;
   logic [PROD_W-1:0]   qsum5_in, qsum5_ff;
   logic [2*SIDE_W-1:0] qa5_in, qa5_ff, qdif5_in, qdif5_ff;
   logic [TAG_AB-1:0]   tag5_ff;

   // Square the Heron terms
   always_comb begin
      qsum5_in = PROD_W'(bsum4_ff) * PROD_W'(bsum4_ff);
      qa5_in   = (2*SIDE_W)'(a4_ff) * (2*SIDE_W)'(a4_ff);
      qdif5_in = (2*SIDE_W)'(bdif4_ff) * (2*SIDE_W)'(bdif4_ff);
   end

   // ---------------------------------------------------------------- stage 6
   command_type        cmd5;
   logic signed [XY_W-1:0] hx, hy;
   logic               x_neg, x_pos, y_neg, y_pos, area_cmd, take;
   logic               v6_ff;
   logic [PROD_W-1:0]  xm6_in, ym6_in, xm6_ff, ym6_ff;
   logic               inv6_in, inv6_ff;
   logic [TAG_AB-1:0]  tag6_ff;

   assign cmd5 = tag5_ff[TAG_AB-1 -: CMD_WIDTH];

   // Form X and Y, flag a negative product, gate degenerate cases and non-area commands to zero
   always_comb begin
      hx       = $signed({1'b0, qsum5_ff}) - $signed(XY_W'(qa5_ff));
      hy       = $signed(XY_W'(qa5_ff)) - $signed(XY_W'(qdif5_ff));
      x_neg    = hx[XY_W-1];
      y_neg    = hy[XY_W-1];
      x_pos    = !x_neg && (hx != '0);
      y_pos    = !y_neg && (hy != '0);
      area_cmd = (cmd5 == CMD_AREA_POINTS) || (cmd5 == CMD_AREA_SIDES);
      take     = area_cmd && x_pos && y_pos;
      inv6_in  = area_cmd && ((x_neg && y_pos) || (y_neg && x_pos));
      xm6_in   = take ? hx[PROD_W-1:0] : '0;
      ym6_in   = take ? hy[PROD_W-1:0] : '0;
   end

   // ------------------------------------------------------- Heron product
   logic                mul_v;
   logic [2*PROD_W-1:0] mul_p;
   logic [TAG_MUL-1:0]  mul_tag;

   dtau_split_mul #(.WIDTH(PROD_W), .TAG_WIDTH(TAG_MUL)) u_mul (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v6_ff),
      .in_a(xm6_ff), .in_b(ym6_ff), .in_tag({tag6_ff, inv6_ff}),
      .out_valid(mul_v), .out_product(mul_p), .out_tag(mul_tag)
   );

   // ---------------------------------------------------------------- stage 8
   command_type       cmd7;
   logic [W-1:0]      dx7, dy7;
   logic [SUM_W-1:0]  ss7;
   logic              inv7;
   logic              v8_ff;
   logic [RAD_W-1:0]  rad8_in, rad8_ff;
   logic [TAG_FIN-1:0] tag8_ff;

   assign {cmd7, dx7, dy7, ss7, inv7} = mul_tag;

   // Select the final radicand: scaled squared distance or Heron product
   always_comb begin
      if (cmd7 == CMD_DISTANCE) begin
         rad8_in = RAD_W'(ss7) << (2 * F);
      end else begin
         rad8_in = RAD_W'(mul_p);
      end
   end

   // ------------------------------------------------------------ final root
   logic               fin_v;
   logic [ROOT_W-1:0]  fin_root;
   logic [TAG_FIN-1:0] fin_tag;

   dtau_isqrt #(.RAD_WIDTH(RAD_W), .TAG_WIDTH(TAG_FIN)) u_sqrt_fin (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v8_ff),
      .in_radicand(rad8_ff), .in_tag(tag8_ff),
      .out_valid(fin_v), .out_root(fin_root), .out_tag(fin_tag)
   );

   // ---------------------------------------------------------------- stage 9
   command_type             cmd_f;
   logic [W-1:0]            dx_f, dy_f;
   logic                    inv_f;
   logic [VAL_W-1:0]        val;
   logic                    v9_ff;
   logic [RSP_DATA_WIDTH-1:0] data9_in, data9_ff;
   logic                    inv9_ff;

   assign {cmd_f, dx_f, dy_f, inv_f} = fin_tag;

   // Scale the area root, saturate and pack the result
   always_comb begin
      if (cmd_f == CMD_DISTANCE) begin
         val = VAL_W'(fin_root);
      end else begin
         val = VAL_W'(fin_root >> 2);
      end
      data9_in[RSP_DATA_WIDTH-1 -: RESULT_WIDTH] =
         (|(val >> RESULT_WIDTH)) ? '1 : val[RESULT_WIDTH-1:0];
      data9_in[DIST_WIDTH-1:0]            = (cmd_f == CMD_DISTANCE) ?
                                            DIST_WIDTH'(dx_f) : '0;
      data9_in[2*DIST_WIDTH-1:DIST_WIDTH] = (cmd_f == CMD_DISTANCE) ?
                                            DIST_WIDTH'(dy_f) : '0;
   end

   // ------------------------------------------------------ pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= ab_v;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v8_ff <= mul_v;
         v9_ff <= fin_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff  <= req_tuser;
         dabx1_ff <= dabx1_in;
         daby1_ff <= daby1_in;
         dbcx1_ff <= dbcx1_in;
         dbcy1_ff <= dbcy1_in;
         dcax1_ff <= dcax1_in;
         dcay1_ff <= dcay1_in;
         sab1_ff  <= req_tdata[6*W +: W];
         sbc1_ff  <= req_tdata[7*W +: W];
         sca1_ff  <= req_tdata[8*W +: W];

         cmd2_ff  <= cmd1_ff;
         qabx2_ff <= qabx2_in;
         qaby2_ff <= qaby2_in;
         qbcx2_ff <= qbcx2_in;
         qbcy2_ff <= qbcy2_in;
         qcax2_ff <= qcax2_in;
         qcay2_ff <= qcay2_in;
         dabx2_ff <= dabx1_ff;
         daby2_ff <= daby1_ff;
         sab2_ff  <= sab1_ff;
         sbc2_ff  <= sbc1_ff;
         sca2_ff  <= sca1_ff;

         cmd3_ff  <= cmd2_ff;
         ssab3_ff <= ssab3_in;
         ssbc3_ff <= ssbc3_in;
         ssca3_ff <= ssca3_in;
         dabx3_ff <= dabx2_ff;
         daby3_ff <= daby2_ff;
         sab3_ff  <= sab2_ff;
         sbc3_ff  <= sbc2_ff;
         sca3_ff  <= sca2_ff;

         bsum4_ff <= bsum4_in;
         bdif4_ff <= bdif4_in;
         a4_ff    <= side_a;
         tag4_ff  <= ab_tag;

         qsum5_ff <= qsum5_in;
         qa5_ff   <= qa5_in;
         qdif5_ff <= qdif5_in;
         tag5_ff  <= tag4_ff;

         xm6_ff   <= xm6_in;
         ym6_ff   <= ym6_in;
         inv6_ff  <= inv6_in;
         tag6_ff  <= tag5_ff;

         rad8_ff  <= rad8_in;
         tag8_ff  <= {cmd7, dx7, dy7, inv7};

         data9_ff <= data9_in;
         inv9_ff  <= inv_f;
      end
   end

   // ------------------------------------------------- output and skid beat
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                      out_inv_ff, out_inv_in;
   logic                      hold_valid_ff, hold_valid_in;
   logic [RSP_DATA_WIDTH-1:0] hold_data_ff, hold_data_in;
   logic                      hold_inv_ff, hold_inv_in;
   logic                      pop;

   assign en   = !hold_valid_ff;
   assign pop  = out_valid_ff && rsp_tready;

   // Drain the skid beat first; otherwise park a finished beat that cannot leave
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_inv_in    = out_inv_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      hold_inv_in   = hold_inv_ff;
      if (hold_valid_ff) begin
         if (pop) begin
            out_data_in   = hold_data_ff;
            out_inv_in    = hold_inv_ff;
            hold_valid_in = 1'b0;
         end
      end else if (v9_ff) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = data9_ff;
            out_inv_in   = inv9_ff;
         end else begin
            hold_valid_in = 1'b1;
            hold_data_in  = data9_ff;
            hold_inv_in   = inv9_ff;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_inv_ff   <= out_inv_in;
      hold_data_ff <= hold_data_in;
      hold_inv_ff  <= hold_inv_in;
   end

   assign req_tready = !hold_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_inv_ff;

   // ------------------------------------------------------------ assertions
   a_side_roots_aligned : assert property (@(posedge clock) disable iff (reset)
      (ab_v == bc_v) && (ab_v == ca_v))
      else $error("side root pipelines out of step");

   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff)
      else $error("skid beat held with empty output register");

   a_invalid_zero_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid beat carries a non-zero result");

   a_skid_holds_pipeline : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |=> ($stable(v9_ff) && $stable(data9_ff)))
      else $error("pipeline moved while skid beat was full");

endmodule

// ===== tb/sv/distance_and_triangle_area_unit_tb.sv =====
// Self-checking testbench of the distance and triangle area unit.
`timescale 1ns / 100ps

module distance_and_triangle_area_unit_tb;
   import dtau_pkg::*;

   localparam int CW       = DEF_COORD_WIDTH;
   localparam int FB       = DEF_FRACTION_BITS;
   localparam int REQ_BITS = ((9*CW+7)/8)*8;
   localparam int LATENCY  = 3*CW + 16;
   localparam command_type CMD_RESERVED = 2'd3;

   typedef struct packed {
      logic [CW-1:0] side_ca, side_bc, side_ab;
      logic [CW-1:0] cy, cx, by, bx, ay, ax;
   } query_fields_type;

   typedef struct {
      command_type      cmd;
      query_fields_type f;
   } query_type;

   typedef struct {
      logic [DIST_WIDTH-1:0]   xd, yd;
      logic [RESULT_WIDTH-1:0] value;
      logic                    invalid;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   command_type req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;

   query_type  pending_queries[$];
   answer_type expected_answers[$];
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_off_cycles = 0;
   int      mismatches = 0;
   int      answers_checked = 0;
   int      queries_sent = 0;
   int      invalid_seen = 0;

   distance_and_triangle_area_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Floor square root of a 128-bit value
   function automatic logic [63:0] floor_root(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
   endfunction

   function automatic logic [63:0] abs_gap(logic signed [CW-1:0] p, logic signed [CW-1:0] q);
      longint d;
      d = longint'(p) - longint'(q);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic [63:0] side_length(logic [CW-1:0] px, logic [CW-1:0] py,
                                               logic [CW-1:0] qx, logic [CW-1:0] qy);
      logic [63:0] dx, dy;
      dx = abs_gap(px, qx);
      dy = abs_gap(py, qy);
      return floor_root({64'd0, dx*dx + dy*dy});
   endfunction

   // Heron area, a quarter of the root of X times Y; flag sides that cannot close a triangle
   function automatic void heron_area(longint a, longint b, longint c,
                                      output logic [31:0] area, output logic inv);
      longint x, y;
      logic [127:0] prod;
      logic [63:0]  root;
      x = (b + c) * (b + c) - a * a;
      y = a * a - (b - c) * (b - c);
      area = '0;
      inv  = 1'b0;
      if ((x < 0 && y > 0) || (y < 0 && x > 0)) inv = 1'b1;
      else if (x > 0 && y > 0) begin
         prod = {64'd0, 64'(x)} * {64'd0, 64'(y)};
         root = floor_root(prod) >> 2;
         area = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
      end
   endfunction

   function automatic answer_type predict_geometry(query_type q);
      answer_type  a;
      logic [63:0] dx, dy, s, root;
      logic [63:0] ab, bc, ca;
      a = '{default: '0};
      case (q.cmd)
         CMD_DISTANCE: begin
            dx = abs_gap(q.f.ax, q.f.bx);
            dy = abs_gap(q.f.ay, q.f.by);
            s = dx*dx + dy*dy;
            root = floor_root({64'd0, s} << (2*FB));
            a.xd = dx[15:0];
            a.yd = dy[15:0];
            a.value = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
         end
         CMD_AREA_POINTS: begin
            ab = side_length(q.f.ax, q.f.ay, q.f.bx, q.f.by);
            bc = side_length(q.f.bx, q.f.by, q.f.cx, q.f.cy);
            ca = side_length(q.f.cx, q.f.cy, q.f.ax, q.f.ay);
            heron_area(ab, bc, ca, a.value, a.invalid);
         end
         CMD_AREA_SIDES:
            heron_area(q.f.side_ab, q.f.side_bc, q.f.side_ca, a.value, a.invalid);
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 1024)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic query_type random_query();
      query_type q;
      int r;
      r = $urandom_range(0, 99);
      q.cmd = (r < 30) ? CMD_DISTANCE : (r < 62) ? CMD_AREA_POINTS :
              (r < 96) ? CMD_AREA_SIDES : CMD_RESERVED;
      q.f.ax = rand_coord(); q.f.ay = rand_coord();
      q.f.bx = rand_coord(); q.f.by = rand_coord();
      q.f.cx = rand_coord(); q.f.cy = rand_coord();
      q.f.side_ab = 16'($urandom);
      q.f.side_bc = 16'($urandom);
      q.f.side_ca = 16'($urandom);
      // mostly sides that close a triangle, with a mix of degenerate ones
      if ($urandom_range(0, 3) != 0) begin
         q.f.side_ab = 16'($urandom_range(0, 32767));
         q.f.side_bc = 16'($urandom_range(0, 32767));
         q.f.side_ca = 16'($urandom_range(
            (q.f.side_ab > q.f.side_bc) ? q.f.side_ab - q.f.side_bc : q.f.side_bc - q.f.side_ab,
            q.f.side_ab + q.f.side_bc));
      end
      return q;
   endfunction

   function automatic query_type make_query(command_type c, logic [CW-1:0] ax,
                                            logic [CW-1:0] ay,
                                            logic [CW-1:0] bx, logic [CW-1:0] by,
                                            logic [CW-1:0] cx, logic [CW-1:0] cy,
                                            logic [CW-1:0] s0, logic [CW-1:0] s1,
                                            logic [CW-1:0] s2);
      query_type q;
      q.cmd = c;
      q.f = '{side_ca: s2, side_bc: s1, side_ab: s0, cy: cy, cx: cx, by: by, bx: bx,
              ay: ay, ax: ax};
      return q;
   endfunction

   // Drive request beats from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_answers.push_back(
               predict_geometry(query_type'{req_tuser, query_fields_type'(req_tdata)}));
            queries_sent++;
         end
         if (pending_queries.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            query_type q;
            q = pending_queries.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_BITS'(q.f);
            req_tuser  <= q.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the response side at random, or hold it off for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_type e;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_tdata);
         end else begin
            e = expected_answers.pop_front();
            answers_checked++;
            if (rsp_tuser) invalid_seen++;
            if (rsp_tdata[15:0] !== e.xd || rsp_tdata[31:16] !== e.yd ||
                rsp_tdata[63:32] !== e.value || rsp_tuser !== e.invalid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected xd %h yd %h value %h inv %b, got %h %h %h %b",
                           e.xd, e.yd, e.value, e.invalid, rsp_tdata[15:0],
                           rsp_tdata[31:16], rsp_tdata[63:32], rsp_tuser);
            end
         end
      end
   end

   task automatic drain();
      while (pending_queries.size() > 0 || req_tvalid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) pending_queries.push_back(random_query());
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, degenerate and impossible triangles
      pending_queries.push_back(make_query(CMD_DISTANCE, 16'h8000, 16'h8000, 16'h7FFF,
                                           16'h7FFF, 0, 0, 0, 0, 0));
      pending_queries.push_back(make_query(CMD_DISTANCE, 16'h7FFF, 16'h8000, 16'h8000,
                                           16'h7FFF, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_queries.push_back(make_query(CMD_DISTANCE, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF,
                                           0, 0, 0));
      pending_queries.push_back(make_query(CMD_DISTANCE, 16'h0300, 16'h0400, 0, 0, 0, 0,
                                           0, 0, 0));
      pending_queries.push_back(make_query(CMD_AREA_POINTS, 0, 0, 16'h0400, 0, 0,
                                           16'h0300, 0, 0, 0));
      pending_queries.push_back(make_query(CMD_AREA_POINTS, 16'h8000, 16'h8000, 16'h7FFF,
                                           16'h8000, 16'h8000, 16'h7FFF, 0, 0, 0));
      pending_queries.push_back(make_query(CMD_AREA_POINTS, 0, 0, 16'h0100, 16'h0100,
                                           16'h0200, 16'h0200, 0, 0, 0));
      pending_queries.push_back(make_query(CMD_AREA_POINTS, 5, 5, 5, 5, 5, 5, 0, 0, 0));
      pending_queries.push_back(make_query(CMD_AREA_SIDES, 0, 0, 0, 0, 0, 0,
                                           16'h0300, 16'h0400, 16'h0500));
      pending_queries.push_back(make_query(CMD_AREA_SIDES, 0, 0, 0, 0, 0, 0,
                                           16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_queries.push_back(make_query(CMD_AREA_SIDES, 0, 0, 0, 0, 0, 0,
                                           16'h0100, 16'h0100, 16'h0500));
      pending_queries.push_back(make_query(CMD_AREA_SIDES, 0, 0, 0, 0, 0, 0,
                                           16'h0100, 16'h0200, 16'h0300));
      pending_queries.push_back(make_query(CMD_AREA_SIDES, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_queries.push_back(make_query(CMD_AREA_SIDES, 0, 0, 0, 0, 0, 0,
                                           16'hFFFF, 0, 16'hFFFF));
      pending_queries.push_back(make_query(CMD_RESERVED, 16'h8000, 16'h7FFF, 16'h1234,
                                           16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF, 1, 2));
      drain();

      // random phases across idling mixes
      run_phase(0, 0, 250);
      run_phase(68, 0, 200);
      run_phase(0, 68, 200);
      run_phase(16, 16, 200);

      // long receiver hold-off so the pipeline fills and stalls the input
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 300;
      run_phase(0, 0, 200);

      repeat (LATENCY + 20) @(posedge clock);
      $display("checked %0d responses over %0d requests, %0d flagged invalid",
               answers_checked, queries_sent, invalid_seen);
      $display("covered all commands, extremes, idle and stall mixes and a full stall");
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("distance_and_triangle_area_unit_tb OK");
      else
         $display("distance_and_triangle_area_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("distance_and_triangle_area_unit_tb NOT OK");
      $finish;
   end

endmodule
